// ===== design/trs_pkg.sv =====
package trs_pkg;

  localparam int TICK_W = 64;
  localparam int REM_W = 64;
  localparam int SCALE_W = 62;
  localparam int UNIT_W = 48;
  localparam int PROD_W = 128;
  localparam int GW_W = 7;
  localparam logic [TICK_W-1:0] STD_TICS_PER_JIFFY = 64'd400;
  localparam logic [TICK_W-1:0] GROUP_MASK_TOP = 64'h7800_0000_0000_0000;

  typedef enum logic [1:0] {
    CFG_SCALE_TOP,
    CFG_SCALE_BOTTOM,
    CFG_UNIT_TICS,
    CFG_UNIT_JIFFIES
  } cfg_idx_t;

  function automatic logic [GW_W-1:0] group_width(input logic [TICK_W-1:0] mag);
    logic [GW_W-1:0] w;
    logic [TICK_W-1:0] m;
    w = GW_W'(1);
    for (int k = 15; k >= 0; k--) begin
      m = GROUP_MASK_TOP >> (4 * k);
      if ((mag & m) != '0) begin
        w = GW_W'(63 - 4 * k);
      end
    end
    return w;
  endfunction

endpackage

// ===== design/trs_div_cell.sv =====
module trs_div_cell #(
  parameter int NUM_W = 64,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [NUM_W-1:0]           in_num,
  input  logic [trs_pkg::REM_W-1:0]  in_rem,
  input  logic [trs_pkg::REM_W-1:0]  in_dvs,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [NUM_W-1:0]           out_num,
  output logic [trs_pkg::REM_W-1:0]  out_rem,
  output logic [trs_pkg::REM_W-1:0]  out_dvs,
  output logic [SIDE_W-1:0]          out_side
);

  logic [trs_pkg::REM_W-1:0] shifted;
  logic                      ge;

  assign shifted = {in_rem[trs_pkg::REM_W-2:0], in_num[NUM_W-1]};
  assign ge = (shifted >= in_dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_num  <= {in_num[NUM_W-2:0], ge};
      out_rem  <= ge ? (shifted - in_dvs) : shifted;
      out_dvs  <= in_dvs;
      out_side <= in_side;
    end
  end

endmodule

// ===== design/trs_div_chain.sv =====
module trs_div_chain #(
  parameter int NUM_W = 64,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [NUM_W-1:0]           in_num,
  input  logic [trs_pkg::REM_W-1:0]  in_dvs,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [NUM_W-1:0]           out_num,
  output logic [trs_pkg::REM_W-1:0]  out_rem,
  output logic [SIDE_W-1:0]          out_side
);

  logic                      v   [NUM_W+1];
  logic [NUM_W-1:0]          num [NUM_W+1];
  logic [trs_pkg::REM_W-1:0] rem [NUM_W+1];
  logic [trs_pkg::REM_W-1:0] dvs [NUM_W+1];
  logic [SIDE_W-1:0]         side[NUM_W+1];

  assign v[0]    = in_valid;
  assign num[0]  = in_num;
  assign rem[0]  = '0;
  assign dvs[0]  = in_dvs;
  assign side[0] = in_side;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    trs_div_cell #(.NUM_W(NUM_W), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[i]),
      .in_num   (num[i]),
      .in_rem   (rem[i]),
      .in_dvs   (dvs[i]),
      .in_side  (side[i]),
      .out_valid(v[i+1]),
      .out_num  (num[i+1]),
      .out_rem  (rem[i+1]),
      .out_dvs  (dvs[i+1]),
      .out_side (side[i+1])
    );
  end

  assign out_valid = v[NUM_W];
  assign out_num   = num[NUM_W];
  assign out_rem   = rem[NUM_W];
  assign out_side  = side[NUM_W];

  // divisor leaving the last cell carries nothing further
  logic unused_dvs;
  assign unused_dvs = ^dvs[NUM_W];

endmodule

// ===== design/tick_rate_scaler.sv =====
// Tick rate scaler: converts signed 64-bit tick counts between a configured
// unit and standard ticks (400 per jiffy). command 0 is unit to standard,
// command 1 standard to unit.
// Input and output channels use valid/stall; a transfer happens when valid
// is high and stall is low. The user must write the configuration port
// (cfg_we, cfg_index, cfg_data) only while no transfer is in flight; the
// block itself does not enforce this. Throughput: one item per cycle while
// out_stall does not hold the pipeline. The result shows on out_valid after
// three chains of restoring divide cells (64 for the period split, 64 for
// the jiffy division, 128 for the scaled quotient) plus input, prepare, two
// multiply and output stages.
// The whole pipeline advances together; when out_stall holds a waiting
// result, the pipeline freezes and in_stall is raised.
// Reset (rst, synchronous) empties the pipeline and loads scale_top 4,
// scale_bottom 1, unit ticks per period 100, unit jiffies per period 1.
module tick_rate_scaler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [trs_pkg::SCALE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic signed [trs_pkg::TICK_W-1:0]  tick_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [trs_pkg::TICK_W-1:0]  converted
);

  localparam int TW = trs_pkg::TICK_W;
  localparam int SIDE_A = 3 + TW;
  localparam int SIDE_C = 1 + TW;

  logic [trs_pkg::SCALE_W-1:0] scale_top, scale_bottom;
  logic [trs_pkg::UNIT_W-1:0]  unit_tics, unit_jiffies;
  logic [TW-1:0] top_e, bot_e, ut_e, uj_e;
  logic [TW-1:0] k_std;
  logic adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_top    <= trs_pkg::SCALE_W'(4);
      scale_bottom <= trs_pkg::SCALE_W'(1);
      unit_tics    <= trs_pkg::UNIT_W'(100);
      unit_jiffies <= trs_pkg::UNIT_W'(1);
    end else if (cfg_we) begin
      case (trs_pkg::cfg_idx_t'(cfg_index))
        trs_pkg::CFG_SCALE_TOP:    scale_top    <= cfg_data;
        trs_pkg::CFG_SCALE_BOTTOM: scale_bottom <= cfg_data;
        trs_pkg::CFG_UNIT_TICS:    unit_tics    <= cfg_data[trs_pkg::UNIT_W-1:0];
        trs_pkg::CFG_UNIT_JIFFIES: unit_jiffies <= cfg_data[trs_pkg::UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero divisors act as one
  assign top_e = (scale_top == '0) ? TW'(1) : TW'(scale_top);
  assign bot_e = (scale_bottom == '0) ? TW'(1) : TW'(scale_bottom);
  assign ut_e  = (unit_tics == '0) ? TW'(1) : TW'(unit_tics);
  assign uj_e  = (unit_jiffies == '0) ? TW'(1) : TW'(unit_jiffies);

  always_ff @(posedge clk) begin
    k_std <= (uj_e << 8) + (uj_e << 7) + (uj_e << 4);
  end

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // input stage
  logic          s0_valid;
  logic          s0_cmd;
  logic [TW-1:0] s0_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cmd  <= command;
      s0_tick <= tick_count;
    end
  end

  // prepare stage: magnitude and split decision
  logic          p_neg, p_split;
  logic [TW-1:0] p_mag, p_d1;
  logic [trs_pkg::GW_W:0] p_gw_sum;

  assign p_neg = s0_tick[TW-1];
  assign p_mag = p_neg ? (TW'(0) - s0_tick) : s0_tick;
  assign p_d1  = s0_cmd ? trs_pkg::STD_TICS_PER_JIFFY : ut_e;
  assign p_gw_sum = {1'b0, trs_pkg::group_width(p_mag)}
                  + {1'b0, trs_pkg::group_width(s0_cmd ? bot_e : top_e)};
  assign p_split = !p_neg && (p_mag >= p_d1) && (p_gw_sum > (trs_pkg::GW_W+1)'(63));

  logic          s1_valid, s1_cmd, s1_neg, s1_split;
  logic [TW-1:0] s1_mag, s1_d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd   <= s0_cmd;
      s1_neg   <= p_neg;
      s1_split <= p_split;
      s1_mag   <= p_mag;
      s1_d1    <= p_d1;
    end
  end

  // period split: q1 = mag / d1, r1 = mag % d1
  logic              a_valid;
  logic [TW-1:0]     a_num, a_rem;
  logic [SIDE_A-1:0] a_side;

  trs_div_chain #(.NUM_W(TW), .SIDE_W(SIDE_A)) u_chain_a (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s1_valid),
    .in_num   (s1_mag),
    .in_dvs   (s1_d1),
    .in_side  ({s1_cmd, s1_neg, s1_split, s1_mag}),
    .out_valid(a_valid),
    .out_num  (a_num),
    .out_rem  (a_rem),
    .out_side (a_side)
  );

  logic          a_cmd, a_neg, a_split;
  logic [TW-1:0] a_mag, a_base, a_dvs;

  assign {a_cmd, a_neg, a_split, a_mag} = a_side;
  assign a_base = a_split ? a_rem : a_mag;
  assign a_dvs  = a_cmd ? uj_e : TW'(1);

  // jiffy division (passes q1 through for unit to standard)
  logic              b_valid;
  logic [TW-1:0]     b_num, b_rem;
  logic [SIDE_A-1:0] b_side;

  trs_div_chain #(.NUM_W(TW), .SIDE_W(SIDE_A)) u_chain_b (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (a_valid),
    .in_num   (a_num),
    .in_dvs   (a_dvs),
    .in_side  ({a_cmd, a_neg, a_split, a_base}),
    .out_valid(b_valid),
    .out_num  (b_num),
    .out_rem  (b_rem),
    .out_side (b_side)
  );

  logic          b_cmd, b_neg, b_split;
  logic [TW-1:0] b_base, b_mul, b_em;

  assign {b_cmd, b_neg, b_split, b_base} = b_side;
  assign b_mul = b_cmd ? bot_e : top_e;
  assign b_em  = b_cmd ? ut_e : k_std;

  // partial products
  logic        m1_valid, m1_cmd, m1_neg, m1_split;
  logic [63:0] p00, p01, p10, p11, e00, e01, e10;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_cmd   <= b_cmd;
      m1_neg   <= b_neg;
      m1_split <= b_split;
      p00 <= 64'(b_base[31:0])  * 64'(b_mul[31:0]);
      p01 <= 64'(b_base[31:0])  * 64'(b_mul[63:32]);
      p10 <= 64'(b_base[63:32]) * 64'(b_mul[31:0]);
      p11 <= 64'(b_base[63:32]) * 64'(b_mul[63:32]);
      e00 <= 64'(b_num[31:0])   * 64'(b_em[31:0]);
      e01 <= 64'(b_num[31:0])   * 64'(b_em[63:32]);
      e10 <= 64'(b_num[63:32])  * 64'(b_em[31:0]);
    end
  end

  // sum partial products
  logic        m2_valid, m2_neg;
  logic [127:0] m2_prod;
  logic [TW-1:0] m2_extra, m2_dvs;
  logic [31:0]   e_mid;

  assign e_mid = e01[31:0] + e10[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_neg   <= m1_neg;
      m2_dvs   <= m1_cmd ? top_e : bot_e;
      m2_prod  <= 128'(p00) + (128'(p01) << 32) + (128'(p10) << 32) + (128'(p11) << 64);
      m2_extra <= m1_split ? (e00 + {e_mid, 32'b0}) : '0;
    end
  end

  // scaled quotient
  logic              c_valid;
  logic [127:0]      c_num;
  logic [TW-1:0]     c_rem;
  logic [SIDE_C-1:0] c_side;

  trs_div_chain #(.NUM_W(trs_pkg::PROD_W), .SIDE_W(SIDE_C)) u_chain_c (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (m2_valid),
    .in_num   (m2_prod),
    .in_dvs   (m2_dvs),
    .in_side  ({m2_neg, m2_extra}),
    .out_valid(c_valid),
    .out_num  (c_num),
    .out_rem  (c_rem),
    .out_side (c_side)
  );

  logic          c_neg;
  logic [TW-1:0] c_extra, c_q, c_res;

  assign {c_neg, c_extra} = c_side;
  assign c_q   = c_num[TW-1:0];
  assign c_res = (c_neg ? (TW'(0) - c_q) : c_q) + c_extra;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      converted <= c_res;
    end
  end

  // remainders of the last two chains carry nothing further
  logic unused_rem;
  assign unused_rem = ^{b_rem, c_rem, c_num[127:TW]};

endmodule

// ===== design/trs_checker.sv =====
module trs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [trs_pkg::TICK_W-1:0]  converted
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(converted))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

endmodule

bind tick_rate_scaler trs_checker u_trs_checker (.*);

// ===== tb/tick_rate_scaler_test.sv =====
`timescale 1ns / 1ps

module tick_rate_scaler_test;

  localparam bit CMD_TO_STD = 1'b0;
  localparam bit CMD_FROM_STD = 1'b1;
  localparam int PIPE_DEPTH = 260;

  class conversion_board;
    bit [trs_pkg::SCALE_W-1:0] top, bottom;
    bit [trs_pkg::UNIT_W-1:0] tics, jiffies;
    bit [trs_pkg::TICK_W-1:0] pending_q[$];
    bit failed;

    function void reset_regs();
      top = 4;
      bottom = 1;
      tics = 100;
      jiffies = 1;
    endfunction

    function void write_reg(trs_pkg::cfg_idx_t idx, bit [trs_pkg::SCALE_W-1:0] d);
      case (idx)
        trs_pkg::CFG_SCALE_TOP: top = d;
        trs_pkg::CFG_SCALE_BOTTOM: bottom = d;
        trs_pkg::CFG_UNIT_TICS: tics = d[trs_pkg::UNIT_W-1:0];
        trs_pkg::CFG_UNIT_JIFFIES: jiffies = d[trs_pkg::UNIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int width_class(bit [trs_pkg::TICK_W-1:0] mag);
      for (int k = 0; k < 16; k++)
        if ((mag & (64'h7800_0000_0000_0000 >> (4 * k))) != 0) return 63 - 4 * k;
      return 1;
    endfunction

    function bit [trs_pkg::TICK_W-1:0] scaled(bit [trs_pkg::TICK_W-1:0] t,
                                              bit [trs_pkg::TICK_W-1:0] mul,
                                              bit [trs_pkg::TICK_W-1:0] dv);
      bit neg;
      bit [trs_pkg::TICK_W-1:0] mag;
      bit [trs_pkg::PROD_W-1:0] p;
      neg = t[trs_pkg::TICK_W-1];
      mag = neg ? -t : t;
      p = {64'b0, mag} * {64'b0, mul};
      p = p / {64'b0, dv};
      return neg ? -p[trs_pkg::TICK_W-1:0] : p[trs_pkg::TICK_W-1:0];
    endfunction

    function void note(bit cmd, bit [trs_pkg::TICK_W-1:0] t);
      bit [trs_pkg::TICK_W-1:0] nt, nb, ut, uj, extra, r;
      nt = (top == 0) ? 1 : top;
      nb = (bottom == 0) ? 1 : bottom;
      ut = (tics == 0) ? 1 : tics;
      uj = (jiffies == 0) ? 1 : jiffies;
      extra = 0;
      if (t == 0) begin
        r = 0;
      end else if (cmd == CMD_TO_STD) begin
        if (!t[63] && t >= ut && width_class(t) + width_class(nt) > 63) begin
          extra = (t / ut) * uj * 400;
          t = t % ut;
        end
        r = extra + scaled(t, nt, nb);
      end else begin
        if (!t[63] && t >= 400 && width_class(t) + width_class(nb) > 63) begin
          extra = ((t / 400) / uj) * ut;
          t = t % 400;
        end
        r = extra + scaled(t, nb, nt);
      end
      pending_q.push_back(r);
    endfunction

    function void check(bit [trs_pkg::TICK_W-1:0] got);
      bit [trs_pkg::TICK_W-1:0] want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected converted %h", $time, got);
        failed = 1;
      end else begin
        want = pending_q.pop_front();
        if (want !== got) begin
          $display("%0t: converted expected %h actual %h", $time, want, got);
          failed = 1;
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [trs_pkg::SCALE_W-1:0] cfg_data;
  logic in_valid, in_stall, command, out_valid, out_stall;
  logic signed [trs_pkg::TICK_W-1:0] tick_count, converted;
  bit busy_phase;
  conversion_board board;

  tick_rate_scaler i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .tick_count(tick_count), .out_valid(out_valid), .out_stall(out_stall),
    .converted(converted)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (busy_phase || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic bit [trs_pkg::TICK_W-1:0] rand_tick();
    bit [trs_pkg::TICK_W-1:0] v;
    int w;
    v = {$urandom, $urandom};
    w = $urandom_range(1, 64);
    if (w < 64) v = v & ((64'd1 << w) - 1);
    if ($urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  function automatic bit [trs_pkg::SCALE_W-1:0] rand_reg(int maxw);
    bit [63:0] v;
    v = {$urandom, $urandom};
    return trs_pkg::SCALE_W'(v & ((64'd1 << $urandom_range(1, maxw)) - 1));
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note(command, tick_count);
    if (!rst && out_valid && !out_stall) board.check(converted);
  end

  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (pick_gap() == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  task automatic send(bit cmd, bit [trs_pkg::TICK_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    tick_count <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(trs_pkg::cfg_idx_t idx, bit [trs_pkg::SCALE_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    board.write_reg(idx, d);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(bit [trs_pkg::SCALE_W-1:0] a, bit [trs_pkg::SCALE_W-1:0] b,
                         bit [trs_pkg::SCALE_W-1:0] c, bit [trs_pkg::SCALE_W-1:0] d);
    write_reg(trs_pkg::CFG_SCALE_TOP, a);
    write_reg(trs_pkg::CFG_SCALE_BOTTOM, b);
    write_reg(trs_pkg::CFG_UNIT_TICS, c);
    write_reg(trs_pkg::CFG_UNIT_JIFFIES, d);
  endtask

  initial begin
    bit [trs_pkg::TICK_W-1:0] edge_vals[12];
    board = new();
    board.reset_regs();
    rst = 1;
    cfg_we = 0;
    cfg_index = trs_pkg::CFG_SCALE_TOP;
    cfg_data = 0;
    in_valid = 0;
    command = CMD_TO_STD;
    tick_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    edge_vals = '{64'd0, 64'd1, -64'sd1, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                  64'd99, 64'd100, 64'd399, 64'd400, 64'h0800_0000_0000_0000,
                  64'h7800_0000_0000_0001, 64'hffff_ffff_0000_0000};
    foreach (edge_vals[i]) begin
      send(CMD_TO_STD, edge_vals[i]);
      send(CMD_FROM_STD, edge_vals[i]);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: set_all('1, '1, '1, '1);
        1: set_all(1, 1, 1, 1);
        2: set_all(0, 0, 0, 0);
        3: set_all(rand_reg(62), 1, 1, rand_reg(48));
        4: set_all(1, rand_reg(62), rand_reg(62), 1);
        default: set_all(rand_reg(62), rand_reg(62), rand_reg(62), rand_reg(62));
      endcase
      busy_phase = (ph == 2 || ph == 5);
      repeat (153) send($urandom_range(0, 1), rand_tick());
    end

    drain();
    repeat (PIPE_DEPTH + 40) @(posedge clk);
    if (!board.failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
